// ----- rtl/bounding_box_and_sphere_macros.svh -----
`ifndef BOUNDING_BOX_AND_SPHERE_MACROS_SVH
`define BOUNDING_BOX_AND_SPHERE_MACROS_SVH

// same-cycle implication, checked on clk, off while arst_n is low
`define BBS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bounding_box_and_sphere: same-cycle check failed");

// next-cycle implication, checked on clk, off while arst_n is low
`define BBS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bounding_box_and_sphere: next-cycle check failed");

`endif

// ----- rtl/bbs_pkg.sv -----
package bbs_pkg;

	typedef struct packed {
		logic accum;
		logic ext_load;
		logic sq_load;
		logic root_start;
		logic corner_next;
		logic clear;
	} bbs_cmd_t;

	typedef struct packed {
		logic root_done;
		logic corner_last;
	} bbs_stat_t;

	localparam logic [2:0] CORNER_LAST = 3'd7;

	// bit k set: corner k takes the max of that axis
	localparam logic [7:0] USE_MAX_X = 8'b0110_1100;
	localparam logic [7:0] USE_MAX_Y = 8'b1100_0110;
	localparam logic [7:0] USE_MAX_Z = 8'b1111_0000;

endpackage

// ----- rtl/bounding_box_and_sphere.sv -----
// Axis-aligned bounding box and bounding sphere of a vertex stream. Vertices
// (signed Q12.12 x,y,z) are taken one per cycle while in_ready is high, and
// the running per-axis min/max is updated. The vertex marked last_vertex is
// folded in, then the block drops in_ready and computes half extents, center
// and radius: extents and center are registered in S_EXT, squares in S_SQ,
// and their sum starts a restoring square root in S_SUM that retires one root
// bit per cycle. Eight corner beats follow in fixed order, each carrying
// center and radius, one per cycle while out_ready is high; in_ready returns
// the cycle after corner 7 is taken, with min/max back at their reset values.
`include "bounding_box_and_sphere_macros.svh"

module bounding_box_and_sphere #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] vert_x,
	input  logic signed [COORD_BITS-1:0] vert_y,
	input  logic signed [COORD_BITS-1:0] vert_z,
	input  logic                         last_vertex,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [2:0]                   corner_index,
	output logic signed [COORD_BITS-1:0] corner_x,
	output logic signed [COORD_BITS-1:0] corner_y,
	output logic signed [COORD_BITS-1:0] corner_z,
	output logic signed [COORD_BITS-1:0] center_x,
	output logic signed [COORD_BITS-1:0] center_y,
	output logic signed [COORD_BITS-1:0] center_z,
	output logic [COORD_BITS-1:0]        radius,
	output logic                         last_corner
);

	bbs_pkg::bbs_cmd_t  cmd;
	bbs_pkg::bbs_stat_t stat;

	bbs_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.last_vertex (last_vertex),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.stat        (stat),
		.cmd         (cmd)
	);

	bbs_dp #(
		.COORD_BITS(COORD_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.vert_x       (vert_x),
		.vert_y       (vert_y),
		.vert_z       (vert_z),
		.corner_index (corner_index),
		.corner_x     (corner_x),
		.corner_y     (corner_y),
		.corner_z     (corner_z),
		.center_x     (center_x),
		.center_y     (center_y),
		.center_z     (center_z),
		.radius       (radius)
	);

	assign last_corner = stat.corner_last;

	`BBS_ASSERT_NOW(a_no_overlap, in_ready, !out_valid)
	`BBS_ASSERT_NOW(a_last_tag, out_valid, last_corner == (corner_index == bbs_pkg::CORNER_LAST))
	`BBS_ASSERT_NEXT(a_reopen, out_valid && out_ready && last_corner, in_ready && !out_valid)
	`BBS_ASSERT_NEXT(a_corner_step, out_valid && out_ready && !last_corner, out_valid && (corner_index == $past(corner_index) + 3'd1))

endmodule

// ----- rtl/bbs_isqrt.sv -----
module bbs_isqrt #(
	parameter int ROOT_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [2*ROOT_BITS-1:0]   radicand,
	output logic [ROOT_BITS-1:0]     root,
	output logic                     done
);

	localparam int RAD_W = 2 * ROOT_BITS;
	localparam int REM_W = ROOT_BITS + 2;
	localparam int CNT_W = $clog2(ROOT_BITS);

	logic [RAD_W-1:0]     rad_q;
	logic [REM_W-1:0]     rem_q;
	logic [REM_W-1:0]     rem_sh;
	logic [REM_W-1:0]     trial;
	logic [ROOT_BITS-1:0] root_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic                 fits;

	always_comb begin
		rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
		trial  = {root_q, 2'b01};
		fits   = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[ROOT_BITS-2:0], fits};
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

// ----- rtl/bbs_dp.sv -----
module bbs_dp #(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bbs_pkg::bbs_cmd_t            cmd,
	output bbs_pkg::bbs_stat_t           stat,
	input  logic signed [COORD_BITS-1:0] vert_x,
	input  logic signed [COORD_BITS-1:0] vert_y,
	input  logic signed [COORD_BITS-1:0] vert_z,
	output logic [2:0]                   corner_index,
	output logic signed [COORD_BITS-1:0] corner_x,
	output logic signed [COORD_BITS-1:0] corner_y,
	output logic signed [COORD_BITS-1:0] corner_z,
	output logic signed [COORD_BITS-1:0] center_x,
	output logic signed [COORD_BITS-1:0] center_y,
	output logic signed [COORD_BITS-1:0] center_z,
	output logic [COORD_BITS-1:0]        radius
);

	localparam int H_W  = COORD_BITS - 1;
	localparam int SQ_W = 2 * H_W;
	localparam int SUM_W = 2 * COORD_BITS;
	localparam logic signed [COORD_BITS-1:0] POS_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] NEG_MAX = {1'b1, {(COORD_BITS-1){1'b0}}};

	logic signed [COORD_BITS-1:0] min_x_q, min_y_q, min_z_q;
	logic signed [COORD_BITS-1:0] max_x_q, max_y_q, max_z_q;
	logic signed [COORD_BITS-1:0] ctr_x_q, ctr_y_q, ctr_z_q;
	logic [H_W-1:0]               h_x_q, h_y_q, h_z_q;
	logic [SQ_W-1:0]              sq_x_q, sq_y_q, sq_z_q;
	logic [COORD_BITS:0]          dif_x, dif_y, dif_z;
	logic [H_W-1:0]               h_x, h_y, h_z;
	logic [SUM_W-1:0]             sum_sq;
	logic [2:0]                   corner_q;
	logic                         root_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_x_q <= POS_MAX;
			min_y_q <= POS_MAX;
			min_z_q <= POS_MAX;
			max_x_q <= NEG_MAX;
			max_y_q <= NEG_MAX;
			max_z_q <= NEG_MAX;
		end else if (cmd.clear) begin
			min_x_q <= POS_MAX;
			min_y_q <= POS_MAX;
			min_z_q <= POS_MAX;
			max_x_q <= NEG_MAX;
			max_y_q <= NEG_MAX;
			max_z_q <= NEG_MAX;
		end else if (cmd.accum) begin
			if (vert_x < min_x_q) min_x_q <= vert_x;
			if (vert_y < min_y_q) min_y_q <= vert_y;
			if (vert_z < min_z_q) min_z_q <= vert_z;
			if (vert_x > max_x_q) max_x_q <= vert_x;
			if (vert_y > max_y_q) max_y_q <= vert_y;
			if (vert_z > max_z_q) max_z_q <= vert_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q <= '0;
		end else if (cmd.corner_next) begin
			corner_q <= corner_q + 3'd1;
		end
	end

	always_comb begin
		dif_x = {max_x_q[COORD_BITS-1], max_x_q} - {min_x_q[COORD_BITS-1], min_x_q};
		dif_y = {max_y_q[COORD_BITS-1], max_y_q} - {min_y_q[COORD_BITS-1], min_y_q};
		dif_z = {max_z_q[COORD_BITS-1], max_z_q} - {min_z_q[COORD_BITS-1], min_z_q};
		h_x   = dif_x[COORD_BITS-1:1];
		h_y   = dif_y[COORD_BITS-1:1];
		h_z   = dif_z[COORD_BITS-1:1];
		sum_sq = SUM_W'(sq_x_q) + SUM_W'(sq_y_q) + SUM_W'(sq_z_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.ext_load) begin
			h_x_q   <= h_x;
			h_y_q   <= h_y;
			h_z_q   <= h_z;
			ctr_x_q <= max_x_q - $signed({1'b0, h_x});
			ctr_y_q <= max_y_q - $signed({1'b0, h_y});
			ctr_z_q <= max_z_q - $signed({1'b0, h_z});
		end
		if (cmd.sq_load) begin
			sq_x_q <= h_x_q * h_x_q;
			sq_y_q <= h_y_q * h_y_q;
			sq_z_q <= h_z_q * h_z_q;
		end
	end

	bbs_isqrt #(
		.ROOT_BITS(COORD_BITS)
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.root_start),
		.radicand (sum_sq),
		.root     (radius),
		.done     (root_done)
	);

	always_comb begin
		stat.root_done   = root_done;
		stat.corner_last = (corner_q == bbs_pkg::CORNER_LAST);
	end

	assign corner_index = corner_q;
	assign corner_x     = bbs_pkg::USE_MAX_X[corner_q] ? max_x_q : min_x_q;
	assign corner_y     = bbs_pkg::USE_MAX_Y[corner_q] ? max_y_q : min_y_q;
	assign corner_z     = bbs_pkg::USE_MAX_Z[corner_q] ? max_z_q : min_z_q;
	assign center_x     = ctr_x_q;
	assign center_y     = ctr_y_q;
	assign center_z     = ctr_z_q;

endmodule

// ----- rtl/bbs_ctrl.sv -----
module bbs_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               last_vertex,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  bbs_pkg::bbs_stat_t stat,
	output bbs_pkg::bbs_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXT,
		S_SQ,
		S_SUM,
		S_ROOT,
		S_EMIT
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;
	logic   in_beat;
	logic   out_beat;

	assign in_beat  = in_valid & in_ready_q;
	assign out_beat = out_valid_q & out_ready;

	always_comb begin
		cmd.accum       = in_beat;
		cmd.ext_load    = (state_q == S_EXT);
		cmd.sq_load     = (state_q == S_SQ);
		cmd.root_start  = (state_q == S_SUM);
		cmd.corner_next = out_beat;
		cmd.clear       = out_beat & stat.corner_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_beat && last_vertex) begin
						state_q    <= S_EXT;
						in_ready_q <= 1'b0;
					end
				end
				S_EXT: begin
					state_q <= S_SQ;
				end
				S_SQ: begin
					state_q <= S_SUM;
				end
				S_SUM: begin
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					if (stat.root_done) begin
						state_q     <= S_EMIT;
						out_valid_q <= 1'b1;
					end
				end
				S_EMIT: begin
					if (out_beat && stat.corner_last) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b0;
						in_ready_q  <= 1'b1;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					in_ready_q  <= 1'b1;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

endmodule
